// File: src/mtg_pkg.sv
package mtg_pkg;

	// Generator dimensions.
	localparam int unsigned STATE_DEPTH = 624;
	localparam int unsigned IDX_W       = $clog2(STATE_DEPTH);
	localparam int unsigned WORD_W      = 32;
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W:0]   TWIST_OFFS = (IDX_W + 1)'(397);
	localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(STATE_DEPTH);

	// Recurrence and tempering constants.
	localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
	localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

	// Input operation codes.
	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_DRAW_C
	} mtg_state_t;

	// Standard output tempering of one state word.
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: src/mtg_ram.sv
module mtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/mersenne_twister_generator_unit.sv
// MT19937 random word generator. A reseed transaction (opcode 1) fills the
// 624-word state memory from seed_value, one word per cycle, so the input
// stalls until the fill is done and no result is produced. A draw
// transaction (opcode 0) regenerates one state word just in time and returns
// its tempered value after the states DRAW_A, DRAW_B and DRAW_C. Those
// steps are set by the single read port of the state memory: the next
// word is read, then the far word (the current word is kept in a register
// from the previous draw). The input stalls until the draw finishes, so a
// new draw is not accepted before the last one is through. A draw before
// the first reseed is accepted and produces no result. The result sits in
// an output register, so the next transaction is accepted while a finished
// word waits to be taken; a draw that finishes while that register is
// still full waits in its last cycle and keeps the input stalled.
module mersenne_twister_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);

	mtg_pkg::mtg_state_t state_q, state_d;

	logic [mtg_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [mtg_pkg::IDX_W-1:0]  cnt_q, cnt_d;
	logic                       seeded_q, seeded_d;
	logic [mtg_pkg::WORD_W-1:0] x_q, x_d;
	logic [mtg_pkg::WORD_W-1:0] cur_q, cur_d;
	logic [mtg_pkg::WORD_W-1:0] nxt_q, nxt_d;
	logic                       out_valid_q, out_valid_d;
	logic [mtg_pkg::WORD_W-1:0] word_q, word_d;

	logic                       mem_we;
	logic [mtg_pkg::IDX_W-1:0]  mem_waddr;
	logic [mtg_pkg::WORD_W-1:0] mem_wdata;
	logic [mtg_pkg::IDX_W-1:0]  mem_raddr;
	logic [mtg_pkg::WORD_W-1:0] mem_rdata;

	logic                       in_take;
	logic                       out_take;
	logic                       out_free;
	logic [mtg_pkg::IDX_W-1:0]  idx_next;
	logic [mtg_pkg::IDX_W:0]    far_sum;
	logic [mtg_pkg::IDX_W-1:0]  idx_far;
	logic [mtg_pkg::WORD_W-1:0] x_mix;
	logic [mtg_pkg::WORD_W-1:0] x_next;
	logic [mtg_pkg::WORD_W-1:0] twist_y;
	logic [mtg_pkg::WORD_W-1:0] twist_v;

	// State memory.
	mtg_ram #(
		.WIDTH(mtg_pkg::WORD_W),
		.DEPTH(mtg_pkg::STATE_DEPTH)
	) u_state_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Handshakes.
	assign in_stall    = (state_q != mtg_pkg::ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign random_word = word_q;
	assign out_take    = out_valid_q && !out_stall;
	assign out_free    = !out_valid_q || !out_stall;

	// Neighbor indexes, modulo the state depth.
	assign idx_next = (idx_q == mtg_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
	assign far_sum  = {1'b0, idx_q} + mtg_pkg::TWIST_OFFS;
	assign idx_far  = (far_sum >= mtg_pkg::DEPTH_EXT) ?
		mtg_pkg::IDX_W'(far_sum - mtg_pkg::DEPTH_EXT) : far_sum[mtg_pkg::IDX_W-1:0];

	// Initialization recurrence for the following word.
	assign x_mix  = x_q ^ (x_q >> 30);
	assign x_next = 32'(mtg_pkg::INIT_MULT * x_mix) + 32'(cnt_q) + 32'd1;

	// Twist of the current word with its neighbor and the far word.
	assign twist_y = (cur_q & mtg_pkg::UPPER_MASK) | (nxt_q & mtg_pkg::LOWER_MASK);
	assign twist_v = mem_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::MATRIX_A : '0);

	// Next state, memory control and output register.
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		seeded_d    = seeded_q;
		x_d         = x_q;
		cur_d       = cur_q;
		nxt_d       = nxt_q;
		out_valid_d = out_take ? 1'b0 : out_valid_q;
		word_d      = word_q;
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = twist_v;
		mem_raddr   = idx_far;
		unique case (state_q)
			mtg_pkg::ST_IDLE: begin
				if (in_take) begin
					if (opcode == mtg_pkg::OP_RESEED) begin
						x_d      = seed_value;
						cur_d    = seed_value;
						cnt_d    = '0;
						idx_d    = '0;
						seeded_d = 1'b1;
						state_d  = mtg_pkg::ST_SEED;
					end else if (seeded_q) begin
						state_d = mtg_pkg::ST_DRAW_A;
					end
				end
			end
			mtg_pkg::ST_SEED: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = x_q;
				x_d       = x_next;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == mtg_pkg::IDX_LAST) begin
					state_d = mtg_pkg::ST_IDLE;
				end
			end
			mtg_pkg::ST_DRAW_A: begin
				mem_raddr = idx_next;
				state_d   = mtg_pkg::ST_DRAW_B;
			end
			mtg_pkg::ST_DRAW_B: begin
				nxt_d   = mem_rdata;
				state_d = mtg_pkg::ST_DRAW_C;
			end
			mtg_pkg::ST_DRAW_C: begin
				if (out_free) begin
					mem_we      = 1'b1;
					out_valid_d = 1'b1;
					word_d      = mtg_pkg::temper(twist_v);
					cur_d       = nxt_q;
					idx_d       = idx_next;
					state_d     = mtg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtg_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtg_pkg::ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			seeded_q    <= seeded_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		x_q    <= x_d;
		cur_q  <= cur_d;
		nxt_q  <= nxt_d;
		word_q <= word_d;
	end

	// The read index stays inside the state memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= mtg_pkg::IDX_LAST)
		else $error("read index out of range");

	// A finished draw advances the read index by one, wrapping at the end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtg_pkg::ST_DRAW_C && out_free) |=>
		(idx_q == (($past(idx_q) == mtg_pkg::IDX_LAST) ? '0 : $past(idx_q) + 1'b1)))
		else $error("read index did not advance after a draw");

	// A new result appears only at the end of a draw.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid_q && !out_stall) && !$past(out_valid_q)) |->
		($past(state_q) == mtg_pkg::ST_DRAW_C))
		else $error("result without a draw");

	// Seeding ends after the last word with the index at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtg_pkg::ST_SEED && cnt_q == mtg_pkg::IDX_LAST) |=>
		(state_q == mtg_pkg::ST_IDLE && seeded_q && idx_q == '0))
		else $error("seeding did not finish cleanly");

	// Draws run only on a seeded generator.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtg_pkg::ST_DRAW_A) |-> seeded_q)
		else $error("draw started before seeding");

endmodule

// File: bench/testbench.sv
module testbench;

	// Generator constants for the prediction.
	localparam logic [31:0] SEED_MULT     = 32'd1812433253;
	localparam logic [31:0] TWIST_XOR     = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
	localparam int unsigned TWIST_SPAN    = 397;
	localparam int unsigned RANDOM_ITEMS  = 1400;
	localparam int unsigned MAX_REPORTS   = 10;

	// One row of the directed stimulus; known marks a typed-in expected word.
	typedef struct packed {
		logic        op;
		logic [31:0] seed;
		logic        known;
		logic [31:0] word;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		// Draws before any seed produce nothing.
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'hffff_ffff, 1'b0, 32'd0},
		// Default seed gives the well-known opening of the stream.
		'{mtg_pkg::OP_RESEED, 32'd5489,      1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612},
		'{mtg_pkg::OP_DRAW,   32'hffff_ffff, 1'b1, 32'd581869302},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd3890346734},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd3586334585},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd545404204},
		// Extreme and small seeds.
		'{mtg_pkg::OP_RESEED, 32'h0000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd2357136044},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_RESEED, 32'h0000_0001, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd1791095845},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_RESEED, 32'hffff_ffff, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'hffff_ffff, 1'b0, 32'd0},
		'{mtg_pkg::OP_RESEED, 32'h8000_0000, 1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b0, 32'd0},
		// A reseed fully restarts the stream.
		'{mtg_pkg::OP_RESEED, 32'd5489,      1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612},
		// Back-to-back reseeds: only the last one counts.
		'{mtg_pkg::OP_RESEED, 32'd12345,     1'b0, 32'd0},
		'{mtg_pkg::OP_RESEED, 32'd5489,      1'b0, 32'd0},
		'{mtg_pkg::OP_DRAW,   32'h0000_0000, 1'b1, 32'd3499211612}
	};

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        opcode     = mtg_pkg::OP_DRAW;
	logic [31:0] seed_value = 32'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [31:0] random_word;

	// Predicted generator state.
	logic [31:0] twister_words [mtg_pkg::STATE_DEPTH];
	int unsigned twister_idx    = 0;
	bit          twister_seeded = 1'b0;

	logic [31:0] expected_words [$];
	int unsigned mismatch_count = 0;
	int unsigned results_seen   = 0;
	int unsigned idle_pct       = 20;
	bit          hold_request   = 1'b0;

	mersenne_twister_generator_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Standard output tempering of a fresh state word.
	function automatic logic [31:0] temper_word(input logic [31:0] w);
		logic [31:0] t;
		t = w;
		t = t ^ (t >> 11);
		t = t ^ ((t << 7) & TEMPER_MASK_B);
		t = t ^ ((t << 15) & TEMPER_MASK_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	// Fill the predicted state with the initialization recurrence.
	function automatic void reseed_twister(input logic [31:0] seed);
		twister_words[0] = seed;
		for (int k = 1; k < mtg_pkg::STATE_DEPTH; k++) begin
			twister_words[k] = SEED_MULT * (twister_words[k-1] ^ (twister_words[k-1] >> 30))
				+ 32'(k);
		end
		twister_idx    = 0;
		twister_seeded = 1'b1;
	endfunction

	// Regenerate the entry at the read index and return its tempered value.
	function automatic bit draw_twister(output logic [31:0] word);
		int unsigned nxt;
		int unsigned far;
		logic [31:0] mixed;
		logic [31:0] fresh;
		word = 32'd0;
		if (!twister_seeded) return 1'b0;
		nxt   = (twister_idx + 1) % mtg_pkg::STATE_DEPTH;
		far   = (twister_idx + TWIST_SPAN) % mtg_pkg::STATE_DEPTH;
		mixed = {twister_words[twister_idx][31], twister_words[nxt][30:0]};
		fresh = twister_words[far] ^ (mixed >> 1);
		if (mixed[0]) fresh = fresh ^ TWIST_XOR;
		twister_words[twister_idx] = fresh;
		twister_idx = nxt;
		word = temper_word(fresh);
		return 1'b1;
	endfunction

	task automatic log_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("Mismatch (%s): expected %h, got %h", what, want, got);
		end
	endtask

	// Offer one transaction, with random idle cycles ahead of it, and predict
	// its result once it is accepted.
	task automatic offer(input logic op, input logic [31:0] seed, input logic known,
			input logic [31:0] known_word);
		logic [31:0] word;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		seed_value <= seed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == mtg_pkg::OP_RESEED) begin
			reseed_twister(seed);
		end else if (draw_twister(word)) begin
			expected_words.push_back(known ? known_word : word);
		end
	endtask

	// Receiver: random stalls, a stall-free stretch, and one long hold-off.
	initial begin
		int unsigned hold_cycles;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_cycles  = 400;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (results_seen >= 500 && results_seen < 800) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 20);
			end
		end
	end

	// Compare each accepted result with the oldest expected word.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				log_mismatch("unexpected result", 32'd0, random_word);
			end else begin
				want = expected_words.pop_front();
				if (random_word !== want) log_mismatch("random_word", want, random_word);
			end
		end
	end

	// Main stimulus sequence.
	initial begin
		logic        pick_op;
		logic [31:0] pick_seed;
		int unsigned roll;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer(DIRECTED[r].op, DIRECTED[r].seed, DIRECTED[r].known, DIRECTED[r].word);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) hold_request = 1'b1;
			// Pause the sender until the block has delivered everything.
			if (n == 700) begin
				in_valid <= 1'b0;
				while (expected_words.size() != 0) @(posedge clk);
			end
			idle_pct = (n >= 900 && n < 1150) ? 0 : 20;

			// Mostly draws; occasional reseeds, some at the seed extremes.
			pick_seed = $urandom;
			pick_op   = mtg_pkg::OP_DRAW;
			if ($urandom_range(99) < 3) begin
				pick_op = mtg_pkg::OP_RESEED;
				roll    = $urandom_range(9);
				if (roll == 0) pick_seed = 32'h0000_0000;
				else if (roll == 1) pick_seed = 32'hffff_ffff;
			end
			offer(pick_op, pick_seed, 1'b0, 32'd0);
		end
		in_valid <= 1'b0;

		// Drain, then allow for a reseed still filling the state memory.
		while (expected_words.size() != 0) @(posedge clk);
		repeat (mtg_pkg::STATE_DEPTH + 50) @(posedge clk);

		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
